// ----- rtl/srtf_pkg.sv -----
package srtf_pkg;

   localparam int TIME_W     = 32;
   localparam int PID_W      = 8;
   localparam int SHORT_W    = 16;
   localparam int SLOT_W     = 4;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 176;

   localparam logic [TIME_W-1:0] TIME_MAX = '1;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_TICK  = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      KIND_LOADED   = 3'd0,
      KIND_REJECTED = 3'd1,
      KIND_IDLE     = 3'd2,
      KIND_RAN      = 3'd3,
      KIND_FINISHED = 3'd4,
      KIND_CLEARED  = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_TURN,
      ST_WAIT,
      ST_EMIT
   } state_type;

   // Best ready process seen so far, passed from cell to cell.
   typedef struct packed {
      logic               found;
      logic [PID_W-1:0]   pid;
      logic [SHORT_W-1:0] arrival;
      logic [SHORT_W-1:0] burst;
      logic [SHORT_W-1:0] remaining;
      logic               started;
      logic [TIME_W-1:0]  first_run;
   } cand_type;

   // Command broadcast from the controller to every cell.
   typedef struct packed {
      logic               load;
      logic               clear;
      logic               update;
      logic [TIME_W-1:0]  cur_time;
      logic [PID_W-1:0]   ld_pid;
      logic [SHORT_W-1:0] ld_arrival;
      logic [SHORT_W-1:0] ld_burst;
      logic [SHORT_W-1:0] up_remaining;
      logic [TIME_W-1:0]  up_first_run;
   } cmd_type;

   typedef struct packed {
      kind_type           kind;
      logic [SLOT_W-1:0]  slot;
      logic [PID_W-1:0]   run_pid;
      logic [TIME_W-1:0]  now;
      logic [TIME_W-1:0]  run_start;
      logic [TIME_W-1:0]  run_finish;
      logic [TIME_W-1:0]  wait_span;
      logic [TIME_W-1:0]  turnaround;
   } res_type;

endpackage

// ----- rtl/srtf_cell.sv -----
module srtf_cell #(
   parameter int IW  = 4,
   parameter int IDX = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  srtf_pkg::cmd_type cmd_in,
   input  logic [IW-1:0]     sel_idx,
   input  srtf_pkg::cand_type cand_in,
   input  logic [IW-1:0]     idx_in,
   output srtf_pkg::cand_type cand_out,
   output logic [IW-1:0]     idx_out
);

   logic                         valid_ff;
   logic                         started_ff;
   logic [srtf_pkg::PID_W-1:0]   pid_ff;
   logic [srtf_pkg::SHORT_W-1:0] arrival_ff;
   logic [srtf_pkg::SHORT_W-1:0] burst_ff;
   logic [srtf_pkg::SHORT_W-1:0] remaining_ff;
   logic [srtf_pkg::TIME_W-1:0]  first_run_ff;
   srtf_pkg::cand_type           cand_ff;
   srtf_pkg::cand_type           cand_in_sel;
   srtf_pkg::cand_type           own;
   logic [IW-1:0]                idx_ff;
   logic [IW-1:0]                idx_in_sel;
   logic                         hit;
   logic                         eligible;
   logic                         better;

   assign hit = (sel_idx == IW'(IDX));

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         started_ff <= 1'b0;
      end else if (cmd_in.clear) begin
         valid_ff   <= 1'b0;
         started_ff <= 1'b0;
      end else if (cmd_in.load && hit) begin
         valid_ff   <= 1'b1;
         started_ff <= 1'b0;
      end else if (cmd_in.update && hit) begin
         started_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_in.load && hit) begin
         pid_ff       <= cmd_in.ld_pid;
         arrival_ff   <= cmd_in.ld_arrival;
         burst_ff     <= cmd_in.ld_burst;
         remaining_ff <= cmd_in.ld_burst;
      end else if (cmd_in.update && hit) begin
         remaining_ff <= cmd_in.up_remaining;
         first_run_ff <= cmd_in.up_first_run;
      end
   end

   always_comb begin
      own.found     = 1'b1;
      own.pid       = pid_ff;
      own.arrival   = arrival_ff;
      own.burst     = burst_ff;
      own.remaining = remaining_ff;
      own.started   = started_ff;
      own.first_run = first_run_ff;
   end

   assign eligible = valid_ff && (remaining_ff != '0) &&
                     ({{(srtf_pkg::TIME_W - srtf_pkg::SHORT_W){1'b0}}, arrival_ff}
                      <= cmd_in.cur_time);

   // Strict compare keeps the candidate from a lower slot on a tie.
   assign better = eligible && (!cand_in.found || (remaining_ff < cand_in.remaining));

   assign cand_in_sel = better ? own : cand_in;
   assign idx_in_sel  = better ? IW'(IDX) : idx_in;

   always_ff @(posedge clock) begin
      cand_ff <= cand_in_sel;
      idx_ff  <= idx_in_sel;
   end

   assign cand_out = cand_ff;
   assign idx_out  = idx_ff;

endmodule

// ----- rtl/srtf_preemptive_scheduler.sv -----
// Shortest-remaining-time-first scheduler over a table of SLOTS process slots.
// Each request transfer carries an operation in req_tuser: load stores a process in
// the next free slot, tick runs the ready process with the least remaining time for
// one time unit, and clear empties the table and zeroes time. Every request yields
// exactly one response transfer whose kind is in rsp_tuser. Requests are handled one
// at a time. The candidate search for a tick runs down a chain of SLOTS slot cells
// that each add one register stage; when the process finishes, the turnaround and
// wait span arithmetic adds two more stages.
module srtf_preemptive_scheduler #(
   parameter int SLOTS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // Fields from bit 0: pid[7:0], arrival[23:8], burst[39:24].
   input  logic [srtf_pkg::REQ_DATA_W-1:0]   req_tdata,
   // Fields from bit 0: operation[1:0].
   input  logic [1:0]                        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // Fields from bit 0: slot[3:0], run_pid[11:4], now[43:12], run_start[75:44],
   // run_finish[107:76], wait_span[139:108], turnaround[171:140], zeros.
   output logic [srtf_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // Fields from bit 0: kind[2:0].
   output logic [2:0]                        rsp_tuser
);

   localparam int IW = $clog2(SLOTS);
   localparam int FW = $clog2(SLOTS + 1);

   srtf_pkg::state_type          state_ff, state_in;
   logic [FW-1:0]                fill_ff, fill_in;
   logic [srtf_pkg::TIME_W-1:0]  time_ff, time_in;
   logic [IW-1:0]                cnt_ff, cnt_in;
   srtf_pkg::cand_type           best_ff, best_in;
   srtf_pkg::res_type            res_ff, res_in;
   srtf_pkg::res_type            rsp_ff, rsp_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   srtf_pkg::cmd_type            cmd;
   logic [IW-1:0]                sel_idx;
   srtf_pkg::cand_type           cand_chain [SLOTS+1];
   logic [IW-1:0]                idx_chain  [SLOTS+1];

   logic                         accept;
   logic                         room;
   srtf_pkg::op_type             op;
   logic [srtf_pkg::PID_W-1:0]   req_pid;
   logic [srtf_pkg::SHORT_W-1:0] req_arrival;
   logic [srtf_pkg::SHORT_W-1:0] req_burst;
   logic [srtf_pkg::TIME_W-1:0]  next_time;
   logic [srtf_pkg::TIME_W:0]    wait_diff;
   srtf_pkg::cand_type           head;

   function automatic logic [srtf_pkg::SLOT_W-1:0] slot_of(input logic [IW-1:0] i);
      logic [IW+srtf_pkg::SLOT_W-1:0] w;
      w = (IW + srtf_pkg::SLOT_W)'(i);
      return w[srtf_pkg::SLOT_W-1:0];
   endfunction

   assign op          = srtf_pkg::op_type'(req_tuser);
   assign req_pid     = req_tdata[7:0];
   assign req_arrival = req_tdata[23:8];
   assign req_burst   = req_tdata[39:24];

   assign req_tready = (state_ff == srtf_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign room       = !rsp_valid_ff || rsp_tready;
   assign next_time  = (time_ff == srtf_pkg::TIME_MAX) ? time_ff : time_ff + 1'b1;
   assign wait_diff  = {1'b0, res_ff.turnaround} -
                       {{(srtf_pkg::TIME_W + 1 - srtf_pkg::SHORT_W){1'b0}}, best_ff.burst};

   always_comb begin
      head       = '0;
      head.found = 1'b0;
   end

   assign cand_chain[0] = head;
   assign idx_chain[0]  = '0;

   for (genvar k = 0; k < SLOTS; k++) begin : g_cell
      srtf_cell #(
         .IW  (IW),
         .IDX (k)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .cmd_in   (cmd),
         .sel_idx  (sel_idx),
         .cand_in  (cand_chain[k]),
         .idx_in   (idx_chain[k]),
         .cand_out (cand_chain[k+1]),
         .idx_out  (idx_chain[k+1])
      );
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         srtf_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = (op == srtf_pkg::OP_TICK) ? srtf_pkg::ST_SCAN : srtf_pkg::ST_EMIT;
            end
         end
         srtf_pkg::ST_SCAN: begin
            if (cnt_ff == IW'(SLOTS - 1)) begin
               state_in = srtf_pkg::ST_DECIDE;
            end
         end
         srtf_pkg::ST_DECIDE: begin
            if (cand_chain[SLOTS].found && (cand_chain[SLOTS].remaining == 16'd1)) begin
               state_in = srtf_pkg::ST_TURN;
            end else begin
               state_in = srtf_pkg::ST_EMIT;
            end
         end
         srtf_pkg::ST_TURN: state_in = srtf_pkg::ST_WAIT;
         srtf_pkg::ST_WAIT: state_in = srtf_pkg::ST_EMIT;
         srtf_pkg::ST_EMIT: begin
            if (room) begin
               state_in = srtf_pkg::ST_IDLE;
            end
         end
         default: state_in = srtf_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd            = '0;
      cmd.cur_time   = time_ff;
      cmd.ld_pid     = req_pid;
      cmd.ld_arrival = req_arrival;
      cmd.ld_burst   = req_burst;
      sel_idx        = '0;
      fill_in        = fill_ff;
      time_in        = time_ff;
      cnt_in         = cnt_ff;
      best_in        = best_ff;
      res_in         = res_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         srtf_pkg::ST_IDLE: begin
            if (accept) begin
               res_in     = '0;
               res_in.now = time_ff;
               case (op)
                  srtf_pkg::OP_LOAD: begin
                     res_in.run_pid = req_pid;
                     if ((fill_ff == FW'(SLOTS)) || (req_burst == '0)) begin
                        res_in.kind = srtf_pkg::KIND_REJECTED;
                     end else begin
                        cmd.load    = 1'b1;
                        sel_idx     = fill_ff[IW-1:0];
                        fill_in     = fill_ff + 1'b1;
                        res_in.kind = srtf_pkg::KIND_LOADED;
                        res_in.slot = slot_of(fill_ff[IW-1:0]);
                     end
                  end
                  srtf_pkg::OP_TICK: begin
                     cnt_in = '0;
                  end
                  srtf_pkg::OP_CLEAR: begin
                     cmd.clear   = 1'b1;
                     fill_in     = '0;
                     time_in     = '0;
                     res_in.kind = srtf_pkg::KIND_CLEARED;
                  end
                  default: begin
                     res_in.kind = srtf_pkg::KIND_REJECTED;
                  end
               endcase
            end
         end
         srtf_pkg::ST_SCAN: begin
            cnt_in = cnt_ff + 1'b1;
         end
         srtf_pkg::ST_DECIDE: begin
            best_in = cand_chain[SLOTS];
            time_in = next_time;
            if (!cand_chain[SLOTS].found) begin
               res_in.kind = srtf_pkg::KIND_IDLE;
            end else begin
               cmd.update       = 1'b1;
               sel_idx          = idx_chain[SLOTS];
               cmd.up_remaining = cand_chain[SLOTS].remaining - 1'b1;
               cmd.up_first_run = cand_chain[SLOTS].started ?
                                  cand_chain[SLOTS].first_run : time_ff;
               res_in.slot      = slot_of(idx_chain[SLOTS]);
               res_in.run_pid   = cand_chain[SLOTS].pid;
               if (cand_chain[SLOTS].remaining == 16'd1) begin
                  res_in.kind       = srtf_pkg::KIND_FINISHED;
                  res_in.run_start  = cmd.up_first_run;
                  res_in.run_finish = next_time;
               end else begin
                  res_in.kind = srtf_pkg::KIND_RAN;
               end
            end
         end
         srtf_pkg::ST_TURN: begin
            res_in.turnaround = res_ff.run_finish -
               {{(srtf_pkg::TIME_W - srtf_pkg::SHORT_W){1'b0}}, best_ff.arrival};
         end
         srtf_pkg::ST_WAIT: begin
            res_in.wait_span = wait_diff[srtf_pkg::TIME_W] ?
                               '0 : wait_diff[srtf_pkg::TIME_W-1:0];
         end
         srtf_pkg::ST_EMIT: begin
            if (room) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && !rsp_tready;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= srtf_pkg::ST_IDLE;
         fill_ff      <= '0;
         time_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         time_ff      <= time_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      best_ff <= best_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tdata  = {4'b0000,
                        rsp_ff.turnaround,
                        rsp_ff.wait_span,
                        rsp_ff.run_finish,
                        rsp_ff.run_start,
                        rsp_ff.now,
                        rsp_ff.run_pid,
                        rsp_ff.slot};

endmodule

// ----- tb/sv/srtf_checker.sv -----
module srtf_checker #(
   parameter int SLOTS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   // Fields from bit 0: pid[7:0], arrival[23:8], burst[39:24].
   input  logic [srtf_pkg::REQ_DATA_W-1:0] req_tdata,
   // Fields from bit 0: operation[1:0].
   input  logic [1:0]                      req_tuser,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // Fields from bit 0: slot, run_pid, now, run_start, run_finish, wait_span,
   // turnaround, zeros.
   input  logic [srtf_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // Fields from bit 0: kind[2:0].
   input  logic [2:0]                      rsp_tuser,
   output int                              mismatches,
   output int                              outstanding,
   output int                              finished_seen
);

   typedef logic [srtf_pkg::TIME_W-1:0]  word_type;
   typedef logic [srtf_pkg::SLOT_W-1:0]  slot_type;
   typedef logic [srtf_pkg::PID_W-1:0]   pid_type;
   typedef logic [srtf_pkg::SHORT_W-1:0] short_type;

   logic                slot_used  [SLOTS];
   pid_type             slot_owner [SLOTS];
   short_type           slot_arr   [SLOTS];
   short_type           slot_len   [SLOTS];
   short_type           slot_left  [SLOTS];
   logic                slot_begun [SLOTS];
   word_type            slot_first [SLOTS];
   word_type            sim_now;
   int                  filled;
   srtf_pkg::res_type   outcome_q [$];

   function automatic void wipe_table();
      for (int i = 0; i < SLOTS; i++) begin
         slot_used[i]  = 1'b0;
         slot_owner[i] = '0;
         slot_arr[i]   = '0;
         slot_len[i]   = '0;
         slot_left[i]  = '0;
         slot_begun[i] = 1'b0;
         slot_first[i] = '0;
      end
      sim_now = '0;
      filled  = 0;
   endfunction

   function automatic srtf_pkg::res_type apply_request(input logic [1:0] op,
                                                       input pid_type    pid,
                                                       input short_type  arr,
                                                       input short_type  bur);
      srtf_pkg::res_type r;
      int                pick;
      word_type          t;
      word_type          tat;
      r      = '0;
      t      = sim_now;
      r.now  = t;
      r.kind = srtf_pkg::KIND_REJECTED;
      pick   = -1;
      case (op)
         srtf_pkg::OP_LOAD: begin
            r.run_pid = pid;
            if (filled < SLOTS && bur != '0) begin
               slot_used[filled]  = 1'b1;
               slot_owner[filled] = pid;
               slot_arr[filled]   = arr;
               slot_len[filled]   = bur;
               slot_left[filled]  = bur;
               slot_begun[filled] = 1'b0;
               slot_first[filled] = '0;
               r.kind = srtf_pkg::KIND_LOADED;
               r.slot = slot_type'(filled);
               filled++;
            end
         end
         srtf_pkg::OP_TICK: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (slot_used[i] && slot_left[i] != '0 && word_type'(slot_arr[i]) <= t &&
                   (pick < 0 || slot_left[i] < slot_left[pick]))
                  pick = i;
            end
            sim_now = (t == srtf_pkg::TIME_MAX) ? t : t + 1'b1;
            if (pick < 0) begin
               r.kind = srtf_pkg::KIND_IDLE;
            end else begin
               if (!slot_begun[pick]) begin
                  slot_begun[pick] = 1'b1;
                  slot_first[pick] = t;
               end
               slot_left[pick] = slot_left[pick] - 1'b1;
               r.slot    = slot_type'(pick);
               r.run_pid = slot_owner[pick];
               if (slot_left[pick] != '0) begin
                  r.kind = srtf_pkg::KIND_RAN;
               end else begin
                  tat = sim_now - word_type'(slot_arr[pick]);
                  r.kind       = srtf_pkg::KIND_FINISHED;
                  r.run_start  = slot_first[pick];
                  r.run_finish = sim_now;
                  r.turnaround = tat;
                  r.wait_span  = (tat >= word_type'(slot_len[pick])) ?
                                 tat - word_type'(slot_len[pick]) : '0;
               end
            end
         end
         srtf_pkg::OP_CLEAR: begin
            wipe_table();
            r.kind = srtf_pkg::KIND_CLEARED;
         end
         default: r.kind = srtf_pkg::KIND_REJECTED;
      endcase
      return r;
   endfunction

   function automatic int field_differs(input string name, input word_type want,
                                        input word_type got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, got %0h", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin : monitor
      srtf_pkg::res_type want;
      srtf_pkg::res_type fresh;
      int                bad;
      if (reset) begin
         wipe_table();
         outcome_q.delete();
         mismatches    = 0;
         finished_seen = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            fresh = apply_request(req_tuser, req_tdata[7:0], req_tdata[23:8],
                                  req_tdata[39:24]);
            outcome_q.insert(outcome_q.size(), fresh);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (outcome_q.size() == 0) begin
               $error("Response transfer of kind %0d arrived with nothing pending.",
                      rsp_tuser);
               mismatches++;
            end else begin
               want = outcome_q.pop_front();
               bad  = 0;
               bad += field_differs("kind", word_type'(want.kind), word_type'(rsp_tuser));
               bad += field_differs("slot", word_type'(want.slot),
                                    word_type'(rsp_tdata[3:0]));
               bad += field_differs("run_pid", word_type'(want.run_pid),
                                    word_type'(rsp_tdata[11:4]));
               bad += field_differs("now", want.now, rsp_tdata[43:12]);
               bad += field_differs("run_start", want.run_start, rsp_tdata[75:44]);
               bad += field_differs("run_finish", want.run_finish, rsp_tdata[107:76]);
               bad += field_differs("wait_span", want.wait_span, rsp_tdata[139:108]);
               bad += field_differs("turnaround", want.turnaround, rsp_tdata[171:140]);
               mismatches += bad;
               if (want.kind == srtf_pkg::KIND_FINISHED)
                  finished_seen++;
            end
         end
      end
      outstanding = outcome_q.size();
   end

endmodule

// ----- tb/sv/tb_srtf_preemptive_scheduler.sv -----
module tb_srtf_preemptive_scheduler;

   localparam logic [1:0] OP_UNKNOWN  = 2'd3;
   localparam int         REQUESTS    = 1150;
   localparam int         STALL_LIMIT = 2000;
   localparam int         SETTLE      = 40;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [srtf_pkg::REQ_DATA_W-1:0] req_tdata;
   logic [1:0]                      req_tuser;
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [srtf_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [2:0]                      rsp_tuser;
   int                              mismatches;
   int                              outstanding;
   int                              finished_seen;
   int                              sent;
   int                              quiet;
   logic                            steady;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   srtf_preemptive_scheduler dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   srtf_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .mismatches    (mismatches),
      .outstanding   (outstanding),
      .finished_seen (finished_seen)
   );

   always @(negedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 23);
   end

   task automatic send(input logic [1:0] op, input logic [7:0] pid,
                       input logic [15:0] arr, input logic [15:0] bur);
      if (!steady) begin
         while ($urandom_range(99) < 23) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
         end
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {bur, arr, pid};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent++;
      steady = (sent >= 500 && sent < 700);
   endtask

   task automatic tick();
      send(srtf_pkg::OP_TICK, 8'($urandom_range(255)), 16'($urandom_range(65535)),
           16'($urandom_range(65535)));
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   // A batch may clear first, loads one to six or 14 to 18 processes and then ticks long enough
   // for the short ones to finish, sometimes loading a short process mid-run to force a preemption.
   task automatic run_batch();
      int          loads;
      int          work;
      int          latest;
      int          ticks;
      logic [15:0] arr;
      logic [15:0] bur;
      if ($urandom_range(3) != 0)
         send(srtf_pkg::OP_CLEAR, 8'($urandom_range(255)), 16'($urandom_range(65535)),
              16'($urandom_range(65535)));
      loads  = ($urandom_range(3) == 0) ? $urandom_range(14, 18) : $urandom_range(1, 6);
      work   = 0;
      latest = 0;
      repeat (loads) begin
         arr = ($urandom_range(7) == 0) ? 16'($urandom_range(65535)) :
                                          16'($urandom_range(12));
         case ($urandom_range(19))
            0:       bur = '0;
            1:       bur = 16'($urandom_range(65535));
            default: bur = 16'($urandom_range(1, 6));
         endcase
         if (arr <= 12 && bur <= 6) begin
            work += bur;
            if (arr > latest)
               latest = arr;
         end
         send(srtf_pkg::OP_LOAD, 8'($urandom_range(255)), arr, bur);
      end
      ticks = work + latest + $urandom_range(0, 4);
      repeat (ticks) begin
         if ($urandom_range(9) == 0) begin
            bur = 16'($urandom_range(1, 3));
            work += bur;
            send(srtf_pkg::OP_LOAD, 8'($urandom_range(255)), 16'($urandom_range(12)), bur);
            tick();
         end
         tick();
      end
   endtask

   initial begin : watchdog
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet = 0;
         else
            quiet++;
      end
      $display("No transfer on either channel for %0d cycles.", STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : stimulus
      int batches;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      rsp_tready = 1'b0;
      steady     = 1'b0;
      sent       = 0;
      batches    = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send(srtf_pkg::OP_TICK, 8'hFF, 16'hFFFF, 16'hFFFF);
      send(OP_UNKNOWN, 8'hFF, 16'hFFFF, 16'hFFFF);
      send(srtf_pkg::OP_LOAD, 8'h00, 16'h0000, 16'h0000);
      send(srtf_pkg::OP_LOAD, 8'hFF, 16'hFFFF, 16'hFFFF);
      send(srtf_pkg::OP_LOAD, 8'h5A, 16'd1, 16'd1);
      send(srtf_pkg::OP_LOAD, 8'hA5, 16'd0, 16'd3);
      send(srtf_pkg::OP_LOAD, 8'h01, 16'd2, 16'd2);
      send(srtf_pkg::OP_LOAD, 8'h02, 16'd2, 16'd2);
      repeat (10) tick();
      send(srtf_pkg::OP_CLEAR, 8'h00, 16'h0000, 16'h0000);
      drain();

      while (sent < REQUESTS) begin
         if ($urandom_range(6) == 0) begin
            repeat ($urandom_range(1, 4))
               send(2'($urandom_range(3)), 8'($urandom_range(255)),
                    16'($urandom_range(65535)), 16'($urandom_range(65535)));
         end else begin
            run_batch();
         end
         batches++;
         if (batches % 10 == 0)
            drain();
      end

      drain();
      repeat (SETTLE) @(posedge clock);
      $display("Drove %0d requests across all four operation codes with random stalls.",
               sent);
      $display("%0d processes ran to completion; every response was compared by field.",
               finished_seen);
      if (mismatches == 0 && outstanding == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
